// File: hw/rtl/gbb3_pkg.sv
// Shared types and constants of the gray box blur block.
package gbb3_pkg;

    // Default image store edge length in pixels.
    localparam int MAX_DIM_DEF = 256;

    // Field widths of the stream channels and the configuration registers.
    localparam int REQ_W      = 2;
    localparam int COORD_W    = 8;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 8;
    localparam int SIZE_REG_W = 9;
    localparam int PASS_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int S_TDATA_W  = 40;

    // Register values after reset.
    localparam logic [SIZE_REG_W-1:0] WIDTH_RST  = 9'd256;
    localparam logic [SIZE_REG_W-1:0] HEIGHT_RST = 9'd256;
    localparam logic [PASS_W-1:0]     PASSES_RST = 5'd1;

    // Gray value: sum of three channels times 2^17/3, rounded up, exact below 2^16.
    localparam int                 GRAY_SUM_W   = 10;
    localparam int                 GRAY_PROD_W  = 26;
    localparam logic [15:0]        GRAY_RECIP   = 16'd43691;
    localparam int                 GRAY_SHIFT   = 17;

    // Blur value: nine-tap sum times 2^16/9, rounded up, exact below 4096.
    localparam int                 BLUR_SUM_W   = 12;
    localparam int                 BLUR_PROD_W  = 25;
    localparam logic [12:0]        BLUR_RECIP   = 13'd7282;
    localparam int                 BLUR_SHIFT   = 16;

    // Request kinds carried on the input tuser.
    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD = 2'd0,
        REQ_RUN  = 2'd1,
        REQ_READ = 2'd2
    } req_type_e;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_BLUR_PASSES  = 2'd2
    } cfg_idx_e;

    // Raw configuration register contents.
    typedef struct packed {
        logic [SIZE_REG_W-1:0] image_width;
        logic [SIZE_REG_W-1:0] image_height;
        logic [PASS_W-1:0]     blur_passes;
    } cfg_regs_t;

endpackage

// File: hw/rtl/gbb3_ram.sv
// Generic single-port synchronous RAM with a registered read.
module gbb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read share the port; read data holds until the next read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

// File: hw/rtl/gbb3_core.sv
// Request sequencer: loads, reads and the blur/copy sweeps over both memories.
module gbb3_core #(
    parameter int MAX_DIM = gbb3_pkg::MAX_DIM_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  gbb3_pkg::cfg_regs_t                       cfg,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [gbb3_pkg::S_TDATA_W-1:0]            s_tdata,
    input  logic [gbb3_pkg::REQ_W-1:0]                s_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [gbb3_pkg::PIX_W-1:0]                m_tdata,
    output logic                                      m_tuser,
    output logic                                      img_we,
    output logic                                      img_re,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]        img_addr,
    output logic [gbb3_pkg::PIX_W-1:0]                img_wdata,
    input  logic [gbb3_pkg::PIX_W-1:0]                img_rdata,
    output logic                                      pass_we,
    output logic                                      pass_re,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]        pass_addr,
    output logic [gbb3_pkg::PIX_W-1:0]                pass_wdata,
    input  logic [gbb3_pkg::PIX_W-1:0]                pass_rdata
);
    import gbb3_pkg::*;

    localparam int AW = $clog2(MAX_DIM*MAX_DIM);
    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM+1);

    typedef enum logic [2:0] {
        IDLE,
        LOAD_WR,
        READ_RESP,
        BLUR_RD,
        BLUR_SUM,
        BLUR_WR,
        COPY_RD,
        COPY_WR
    } state_t;

    state_t                 state_reg;
    logic [CW-1:0]          x_reg;
    logic [CW-1:0]          y_reg;
    logic [1:0]             tx_reg;
    logic [1:0]             ty_reg;
    logic                   pend_reg;
    logic [BLUR_SUM_W-1:0]  acc_reg;
    logic [GRAY_SUM_W-1:0]  gsum_reg;
    logic [AW-1:0]          addr_reg;
    logic [PASS_W-1:0]      pass_cnt_reg;
    logic                   err_reg;
    logic                   m_tvalid_reg;
    logic [PIX_W-1:0]       m_data_reg;
    logic                   m_err_reg;

    logic [DW-1:0]          w_use;
    logic [DW-1:0]          h_use;
    logic [COORD_W-1:0]     in_col;
    logic [COORD_W-1:0]     in_row;
    logic [CHAN_W-1:0]      in_red;
    logic [CHAN_W-1:0]      in_green;
    logic [CHAN_W-1:0]      in_blue;
    logic                   in_area;
    logic [AW-1:0]          in_addr;
    logic                   x_last;
    logic                   y_last;
    logic [CW-1:0]          nx;
    logic [CW-1:0]          ny;
    logic [GRAY_PROD_W-1:0] gray_prod;
    logic [BLUR_PROD_W-1:0] blur_prod;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] cx,
                                                 input logic [CW-1:0] cy);
        return AW'(AW'(cy) * AW'(MAX_DIM) + AW'(cx));
    endfunction

    // Sizes in use: zero reads as one, anything above the store edge as the edge.
    assign w_use = (cfg.image_width == '0) ? DW'(1) :
                   (32'(cfg.image_width) > 32'(MAX_DIM)) ? DW'(MAX_DIM) :
                   DW'(cfg.image_width);
    assign h_use = (cfg.image_height == '0) ? DW'(1) :
                   (32'(cfg.image_height) > 32'(MAX_DIM)) ? DW'(MAX_DIM) :
                   DW'(cfg.image_height);

    // Input payload fields.
    assign in_col   = s_tdata[0  +: COORD_W];
    assign in_row   = s_tdata[8  +: COORD_W];
    assign in_red   = s_tdata[16 +: CHAN_W];
    assign in_green = s_tdata[24 +: CHAN_W];
    assign in_blue  = s_tdata[32 +: CHAN_W];
    assign in_area  = (32'(in_col) < 32'(w_use)) && (32'(in_row) < 32'(h_use));
    assign in_addr  = AW'(AW'(in_row) * AW'(MAX_DIM) + AW'(in_col));

    // Sweep position and the clamped neighbor of the current tap.
    assign x_last = (DW'(x_reg) == w_use - DW'(1));
    assign y_last = (DW'(y_reg) == h_use - DW'(1));

    always_comb begin
        nx = x_reg;
        ny = y_reg;
        if (tx_reg == 2'd0 && x_reg != '0) begin
            nx = x_reg - CW'(1);
        end else if (tx_reg == 2'd2 && !x_last) begin
            nx = x_reg + CW'(1);
        end
        if (ty_reg == 2'd0 && y_reg != '0) begin
            ny = y_reg - CW'(1);
        end else if (ty_reg == 2'd2 && !y_last) begin
            ny = y_reg + CW'(1);
        end
    end

    // Reciprocal multiplies for the divide by three and by nine.
    assign gray_prod = GRAY_PROD_W'(gsum_reg) * GRAY_PROD_W'(GRAY_RECIP);
    assign blur_prod = BLUR_PROD_W'(acc_reg) * BLUR_PROD_W'(BLUR_RECIP);

    // Memory port steering by state.
    always_comb begin
        img_re     = 1'b0;
        img_we     = 1'b0;
        img_addr   = cell_addr(x_reg, y_reg);
        img_wdata  = pass_rdata;
        pass_re    = (state_reg == COPY_RD);
        pass_we    = (state_reg == BLUR_WR);
        pass_addr  = cell_addr(x_reg, y_reg);
        pass_wdata = blur_prod[BLUR_SHIFT +: PIX_W];
        case (state_reg)
            IDLE: begin
                img_re   = s_tvalid && (s_tuser == REQ_READ);
                img_addr = in_addr;
            end
            LOAD_WR: begin
                img_we    = 1'b1;
                img_addr  = addr_reg;
                img_wdata = gray_prod[GRAY_SHIFT +: PIX_W];
            end
            BLUR_RD: begin
                img_re   = 1'b1;
                img_addr = cell_addr(nx, ny);
            end
            COPY_WR: begin
                img_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_err_reg;

    // Sequencer state, sweep counters and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            x_reg        <= '0;
            y_reg        <= '0;
            tx_reg       <= '0;
            ty_reg       <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // A tap read issued in this cycle returns data in the next one.
            pend_reg <= (state_reg == BLUR_RD);
            if (m_tvalid_reg && m_tready && (state_reg != READ_RESP)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (s_tvalid) begin
                        case (req_type_e'(s_tuser))
                            REQ_LOAD: begin
                                if (in_area) begin
                                    addr_reg  <= in_addr;
                                    gsum_reg  <= GRAY_SUM_W'(in_red) + GRAY_SUM_W'(in_green)
                                               + GRAY_SUM_W'(in_blue);
                                    state_reg <= LOAD_WR;
                                end
                            end
                            REQ_RUN: begin
                                if (cfg.blur_passes != '0) begin
                                    pass_cnt_reg <= cfg.blur_passes;
                                    state_reg    <= BLUR_RD;
                                end
                            end
                            REQ_READ: begin
                                err_reg   <= !in_area;
                                state_reg <= READ_RESP;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                LOAD_WR: begin
                    state_reg <= IDLE;
                end
                READ_RESP: begin
                    // Hold the read data in the RAM until the output register frees up.
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_data_reg   <= err_reg ? '0 : img_rdata;
                        m_err_reg    <= err_reg;
                        state_reg    <= IDLE;
                    end
                end
                BLUR_RD: begin
                    // One tap read per cycle; the previous tap's data lands now.
                    acc_reg  <= ((tx_reg == 2'd0 && ty_reg == 2'd0) ? '0 : acc_reg)
                              + (pend_reg ? BLUR_SUM_W'(img_rdata) : '0);
                    if (tx_reg == 2'd2) begin
                        tx_reg <= '0;
                        if (ty_reg == 2'd2) begin
                            ty_reg    <= '0;
                            state_reg <= BLUR_SUM;
                        end else begin
                            ty_reg <= ty_reg + 2'd1;
                        end
                    end else begin
                        tx_reg <= tx_reg + 2'd1;
                    end
                end
                BLUR_SUM: begin
                    acc_reg   <= acc_reg + BLUR_SUM_W'(img_rdata);
                    state_reg <= BLUR_WR;
                end
                BLUR_WR: begin
                    x_reg <= x_last ? '0 : x_reg + CW'(1);
                    if (x_last) begin
                        y_reg <= y_last ? '0 : y_reg + CW'(1);
                    end
                    state_reg <= (x_last && y_last) ? COPY_RD : BLUR_RD;
                end
                COPY_RD: begin
                    state_reg <= COPY_WR;
                end
                COPY_WR: begin
                    x_reg <= x_last ? '0 : x_reg + CW'(1);
                    if (x_last) begin
                        y_reg <= y_last ? '0 : y_reg + CW'(1);
                    end
                    if (x_last && y_last) begin
                        if (pass_cnt_reg == PASS_W'(1)) begin
                            state_reg <= IDLE;
                        end else begin
                            pass_cnt_reg <= pass_cnt_reg - PASS_W'(1);
                            state_reg    <= BLUR_RD;
                        end
                    end else begin
                        state_reg <= COPY_RD;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    // The image memory port never reads and writes in the same cycle.
    a_img_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(img_we && img_re))
        else $error("image memory read and write in the same cycle");

    // The sweep position stays inside the image area in use.
    a_pos_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(x_reg) < 32'(w_use)) && (32'(y_reg) < 32'(h_use)))
        else $error("sweep position outside the image area");

    // Tap counters walk a 3x3 window.
    a_tap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (tx_reg != 2'd3) && (ty_reg != 2'd3))
        else $error("tap counter outside the window");

    // A result appears only after a read response cycle.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == READ_RESP))
        else $error("result raised outside a read response");

    // A pixel sum is written only after all nine taps were gathered.
    a_sum_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BLUR_WR) |-> $past(state_reg == BLUR_SUM))
        else $error("blur write without a completed tap sum");

endmodule

// File: hw/rtl/gray_box_blur_3x3_clamped.sv
// Top level of the gray image store with a clamped 3x3 box blur.
//
// Input stream (s_*): one request per transfer; tuser carries the request
// kind (load, run, read), tdata the pixel column, row and RGB channels.
// Output stream (m_*): one transfer per read request with the stored value
// in tdata and a range error flag in tuser.
// Configuration channel (cfg_*): always ready; index 0 sets the width in
// use, 1 the height, 2 the number of blur passes per run.
//
// A load is accepted and then written to memory. For a read, the
// memory lookup is issued in the accept cycle, the response cycle moves the
// data into the output register, and m_tvalid is high from the cycle after.
// A run with a nonzero pass count holds off input until all passes are
// done: each pixel needs nine single-port reads of the image memory plus
// a sum and a write into the pass buffer, and the copy back then reads
// each pixel from the pass buffer and writes it to the image memory.
// A finished result waits in the output register while the receiver stalls;
// new requests are still taken meanwhile, and a further read waits in its
// response cycle until that register is free.
// Reset sets the size to 256 x 256 and the pass count to 1; the memories
// are not cleared, and every pixel in use must be loaded before a run.
module gray_box_blur_3x3_clamped #(
    parameter int MAX_DIM = gbb3_pkg::MAX_DIM_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gbb3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbb3_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // col [7:0], row [15:8], red [23:16], green [31:24], blue [39:32]
    input  logic [gbb3_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type [1:0]
    input  logic [gbb3_pkg::REQ_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_value [7:0]
    output logic [gbb3_pkg::PIX_W-1:0]      m_tdata,
    // range_error [0]
    output logic                            m_tuser
);
    import gbb3_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    cfg_regs_t        cfg_reg;
    logic             img_we;
    logic             img_re;
    logic [AW-1:0]    img_addr;
    logic [PIX_W-1:0] img_wdata;
    logic [PIX_W-1:0] img_rdata;
    logic             pass_we;
    logic             pass_re;
    logic [AW-1:0]    pass_addr;
    logic [PIX_W-1:0] pass_wdata;
    logic [PIX_W-1:0] pass_rdata;

    assign cfg_ready = 1'b1;

    // Configuration registers keep the written bits; the core clamps them.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= WIDTH_RST;
            cfg_reg.image_height <= HEIGHT_RST;
            cfg_reg.blur_passes  <= PASSES_RST;
        end else if (cfg_valid) begin
            case (cfg_idx_e'(cfg_index))
                CFG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data[SIZE_REG_W-1:0];
                CFG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data[SIZE_REG_W-1:0];
                CFG_BLUR_PASSES:  cfg_reg.blur_passes  <= cfg_data[PASS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Request sequencer.
    gbb3_core #(
        .MAX_DIM (MAX_DIM)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .img_we     (img_we),
        .img_re     (img_re),
        .img_addr   (img_addr),
        .img_wdata  (img_wdata),
        .img_rdata  (img_rdata),
        .pass_we    (pass_we),
        .pass_re    (pass_re),
        .pass_addr  (pass_addr),
        .pass_wdata (pass_wdata),
        .pass_rdata (pass_rdata)
    );

    // Image memory, addressed row * MAX_DIM + col.
    gbb3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_image_store (
        .aclk  (aclk),
        .we    (img_we),
        .re    (img_re),
        .addr  (img_addr),
        .wdata (img_wdata),
        .rdata (img_rdata)
    );

    // Buffer for the results of the pass in progress.
    gbb3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_pass_buffer (
        .aclk  (aclk),
        .we    (pass_we),
        .re    (pass_re),
        .addr  (pass_addr),
        .wdata (pass_wdata),
        .rdata (pass_rdata)
    );

endmodule

// File: verif/blur_checker.sv
`timescale 1ns / 1ps
// Checker for the gray box blur block: predicts read results from the observed transfers.
module blur_checker #(
    parameter int MAX_DIM = gbb3_pkg::MAX_DIM_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [gbb3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbb3_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [gbb3_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [gbb3_pkg::REQ_W-1:0]      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [gbb3_pkg::PIX_W-1:0]      m_tdata,
    input  logic                            m_tuser,
    output int                              mismatch_count,
    output int                              reads_pending
);
    import gbb3_pkg::*;

    localparam int CELLS = MAX_DIM * MAX_DIM;

    // One read result as it should leave the block.
    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             range_error;
    } read_result_t;

    read_result_t     read_results_due[$];
    logic [PIX_W-1:0] gray_image [CELLS];
    logic [PIX_W-1:0] blurred_image [CELLS];
    cfg_regs_t        regs;

    // A size register of 0 acts as 1 and anything above the store edge as the edge.
    function automatic int dim_in_use(logic [SIZE_REG_W-1:0] size_reg);
        if (size_reg == '0) return 1;
        if (int'(size_reg) > MAX_DIM) return MAX_DIM;
        return int'(size_reg);
    endfunction

    function automatic int clamp_to(int v, int n);
        if (v < 0) return 0;
        if (v >= n) return n - 1;
        return v;
    endfunction

    // One box blur pass: all new values come from the old image, then get copied back.
    task automatic blur_pass(int w, int h);
        int sum;
        int sx;
        int sy;
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                sum = 0;
                for (int dy = -1; dy <= 1; dy++) begin
                    for (int dx = -1; dx <= 1; dx++) begin
                        sx = clamp_to(x + dx, w);
                        sy = clamp_to(y + dy, h);
                        sum += int'(gray_image[sy * MAX_DIM + sx]);
                    end
                end
                blurred_image[y * MAX_DIM + x] = PIX_W'(sum / 9);
            end
        end
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                gray_image[y * MAX_DIM + x] = blurred_image[y * MAX_DIM + x];
            end
        end
    endtask

    // Watch all three channels; results are matched before new requests are taken in,
    // since a read accepted at this edge cannot have its result out yet.
    always @(posedge aclk) begin
        int           col;
        int           row;
        int           w;
        int           h;
        int           chan_sum;
        read_result_t want;
        read_result_t got;
        if (!aresetn) begin
            regs.image_width  = WIDTH_RST;
            regs.image_height = HEIGHT_RST;
            regs.blur_passes  = PASSES_RST;
            read_results_due.delete();
        end else begin
            // Register writes.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  regs.image_width  = cfg_data;
                    CFG_IMAGE_HEIGHT: regs.image_height = cfg_data;
                    CFG_BLUR_PASSES:  regs.blur_passes  = cfg_data[PASS_W-1:0];
                    default: ;
                endcase
            end

            // Result transfers against the oldest pending read.
            if (m_tvalid && m_tready) begin
                got.pixel_value = m_tdata;
                got.range_error = m_tuser;
                if (read_results_due.size() == 0) begin
                    $error("result with no read pending: pixel_value %0d, range_error %0d",
                           got.pixel_value, got.range_error);
                    mismatch_count++;
                end else begin
                    want = read_results_due.pop_front();
                    if (got.pixel_value !== want.pixel_value) begin
                        $error("pixel_value: expected %0d, actual %0d",
                               want.pixel_value, got.pixel_value);
                        mismatch_count++;
                    end
                    if (got.range_error !== want.range_error) begin
                        $error("range_error: expected %0d, actual %0d",
                               want.range_error, got.range_error);
                        mismatch_count++;
                    end
                end
            end

            // Request transfers update the image copy or queue a read result.
            if (s_tvalid && s_tready) begin
                col = int'(s_tdata[7:0]);
                row = int'(s_tdata[15:8]);
                w   = dim_in_use(regs.image_width);
                h   = dim_in_use(regs.image_height);
                case (s_tuser)
                    REQ_LOAD: begin
                        if (col < w && row < h) begin
                            chan_sum = int'(s_tdata[23:16]) + int'(s_tdata[31:24])
                                     + int'(s_tdata[39:32]);
                            gray_image[row * MAX_DIM + col] = PIX_W'(chan_sum / 3);
                        end
                    end
                    REQ_RUN: begin
                        repeat (int'(regs.blur_passes)) blur_pass(w, h);
                    end
                    REQ_READ: begin
                        if (col < w && row < h) begin
                            want.pixel_value = gray_image[row * MAX_DIM + col];
                            want.range_error = 1'b0;
                        end else begin
                            want.pixel_value = '0;
                            want.range_error = 1'b1;
                        end
                        read_results_due.push_back(want);
                    end
                    default: ;
                endcase
            end
        end
        reads_pending = read_results_due.size();
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the gray box blur block: clock, reset, requests and the verdict.
module tb_top;
    import gbb3_pkg::*;

    localparam int RESET_CYCLES    = 10;
    localparam int ITEM_TARGET     = 1050;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int HOLD_CYCLES     = 400;
    // Largest width * height * passes for a run, which keeps every run short.
    localparam int RUN_BUDGET      = 256;
    // Areas up to this size get fully loaded so that runs are allowed on them.
    localparam int SWEEP_AREA      = 256;
    localparam int CELLS           = MAX_DIM_DEF * MAX_DIM_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [REQ_W-1:0]     REQ_NONE   = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [REQ_W-1:0]      s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [PIX_W-1:0]      m_tdata;
    logic                  m_tuser;

    int mismatch_count;
    int reads_pending;

    // Stimulus-side view of the registers and of which pixels hold data.
    logic [SIZE_REG_W-1:0] width_reg  = WIDTH_RST;
    logic [SIZE_REG_W-1:0] height_reg = HEIGHT_RST;
    bit                    cell_loaded [CELLS];
    int                    loaded_cells[$];
    int                    items_sent;
    int                    cycle_count;
    bit                    sender_steady;
    bit                    hold_request;

    always #5 aclk = ~aclk;

    gray_box_blur_3x3_clamped u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    blur_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .reads_pending  (reads_pending)
    );

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int used_dim(logic [SIZE_REG_W-1:0] size_reg);
        if (size_reg == '0) return 1;
        if (int'(size_reg) > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(size_reg);
    endfunction

    // Idle length: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Channel values lean toward the extremes.
    function automatic logic [7:0] channel_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 8'd0;
        if (roll == 1) return 8'd255;
        return 8'($urandom);
    endfunction

    // Size register value for a random phase: mostly tiny images, some odd ones.
    function automatic logic [SIZE_REG_W-1:0] random_dim();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7) return SIZE_REG_W'($urandom_range(1, 8));
        if (roll == 7) return SIZE_REG_W'($urandom_range(9, 64));
        if (roll == 8) return SIZE_REG_W'($urandom_range(65, 511));
        return '0;
    endfunction

    function automatic bit area_loaded();
        for (int y = 0; y < used_dim(height_reg); y++) begin
            for (int x = 0; x < used_dim(width_reg); x++) begin
                if (!cell_loaded[y * MAX_DIM_DEF + x]) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // A loaded pixel inside the size in use; never a pixel that holds no data.
    function automatic bit pick_loaded_inside(output int col, output int row);
        int idx;
        col = 0;
        row = 0;
        for (int tries = 0; tries < 8; tries++) begin
            col = $urandom_range(0, used_dim(width_reg) - 1);
            row = $urandom_range(0, used_dim(height_reg) - 1);
            if (cell_loaded[row * MAX_DIM_DEF + col]) return 1'b1;
        end
        if (loaded_cells.size() == 0) return 1'b0;
        for (int tries = 0; tries < 32; tries++) begin
            idx = loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
            col = idx % MAX_DIM_DEF;
            row = idx / MAX_DIM_DEF;
            if (col < used_dim(width_reg) && row < used_dim(height_reg)) return 1'b1;
        end
        return 1'b0;
    endfunction

    // A coordinate beyond the size in use, if the size leaves room for one.
    function automatic bit pick_outside(output int col, output int row);
        int w;
        int h;
        w   = used_dim(width_reg);
        h   = used_dim(height_reg);
        col = 0;
        row = 0;
        if (w == MAX_DIM_DEF && h == MAX_DIM_DEF) return 1'b0;
        if (w < MAX_DIM_DEF && (h == MAX_DIM_DEF || $urandom_range(0, 1) == 1)) begin
            col = $urandom_range(w, MAX_DIM_DEF - 1);
            row = $urandom_range(0, MAX_DIM_DEF - 1);
        end else begin
            col = $urandom_range(0, MAX_DIM_DEF - 1);
            row = $urandom_range(h, MAX_DIM_DEF - 1);
        end
        return 1'b1;
    endfunction

    // Offer one request and hold it until the transfer happens. Valid stays high
    // between back-to-back requests.
    task automatic send_request(logic [REQ_W-1:0] kind, int col, int row,
                                logic [7:0] red, logic [7:0] green, logic [7:0] blue);
        int gap;
        int idx;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {blue, green, red, row[7:0], col[7:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (kind != REQ_NONE) items_sent++;
        if (kind == REQ_LOAD && col < used_dim(width_reg) && row < used_dim(height_reg)) begin
            idx = row * MAX_DIM_DEF + col;
            if (!cell_loaded[idx]) begin
                cell_loaded[idx] = 1'b1;
                loaded_cells.push_back(idx);
            end
        end
    endtask

    task automatic random_read();
        int  col;
        int  row;
        bit  found;
        found = 1'b0;
        if ($urandom_range(0, 3) == 0) found = pick_outside(col, row);
        if (!found) found = pick_loaded_inside(col, row);
        if (!found) found = pick_outside(col, row);
        if (found) send_request(REQ_READ, col, row, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic random_load();
        int col;
        int row;
        if ($urandom_range(0, 4) != 0 || !pick_outside(col, row)) begin
            col = $urandom_range(0, used_dim(width_reg) - 1);
            row = $urandom_range(0, used_dim(height_reg) - 1);
        end
        send_request(REQ_LOAD, col, row, channel_value(), channel_value(), channel_value());
    endtask

    // Stop offering requests and wait until every read result has come back,
    // plus a margin for a trailing load write.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (reads_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_IMAGE_WIDTH:  width_reg  = value;
            CFG_IMAGE_HEIGHT: height_reg = value;
            default: ;
        endcase
    endtask

    task automatic configure(logic [SIZE_REG_W-1:0] w, logic [SIZE_REG_W-1:0] h,
                             logic [PASS_W-1:0] passes);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_BLUR_PASSES, CFG_DATA_W'(passes));
        cfg_valid <= 1'b0;
    endtask

    // One phase: set the size and pass count, fill small images completely, then a
    // random mix of loads, reads and runs. A read closes the phase, so its result
    // cannot arrive before a run still in progress has finished.
    task automatic run_phase(int phase_idx);
        logic [SIZE_REG_W-1:0] w_reg;
        logic [SIZE_REG_W-1:0] h_reg;
        logic [PASS_W-1:0]     passes;
        int                    area;
        int                    max_passes;
        int                    read_pct;
        int                    roll;
        bit                    runs_ok;
        case (phase_idx)
            0: begin
                w_reg  = '0;
                h_reg  = '1;
                passes = PASS_W'(1);
            end
            1: begin
                w_reg  = '1;
                h_reg  = '0;
                passes = PASS_W'(1);
            end
            2: begin
                w_reg  = SIZE_REG_W'(MAX_DIM_DEF);
                h_reg  = SIZE_REG_W'(MAX_DIM_DEF);
                passes = '1;
            end
            default: begin
                w_reg = random_dim();
                h_reg = random_dim();
                area  = used_dim(w_reg) * used_dim(h_reg);
                if (area <= SWEEP_AREA) begin
                    max_passes = RUN_BUDGET / area;
                    if (max_passes > 31) max_passes = 31;
                    passes = PASS_W'($urandom_range(0, max_passes));
                end else begin
                    passes = PASS_W'($urandom_range(0, 31));
                end
            end
        endcase
        configure(w_reg, h_reg, passes);

        sender_steady = ($urandom_range(0, 3) == 0);
        read_pct      = 45;
        // Read-heavy burst while the receiver holds off, so the block backs up.
        if (phase_idx == 3) begin
            sender_steady = 1'b1;
            read_pct      = 85;
            hold_request  = 1'b1;
        end

        area = used_dim(width_reg) * used_dim(height_reg);
        if (area <= SWEEP_AREA) begin
            for (int y = 0; y < used_dim(height_reg); y++) begin
                for (int x = 0; x < used_dim(width_reg); x++) begin
                    if (!cell_loaded[y * MAX_DIM_DEF + x]) begin
                        send_request(REQ_LOAD, x, y, channel_value(), channel_value(),
                                     channel_value());
                    end
                end
            end
        end
        runs_ok = area_loaded() && (area * int'(passes) <= RUN_BUDGET);

        repeat ($urandom_range(40, 90)) begin
            roll = $urandom_range(0, 99);
            if (roll < read_pct) begin
                random_read();
            end else if (roll < read_pct + 6 && runs_ok) begin
                send_request(REQ_RUN, $urandom_range(0, 255), $urandom_range(0, 255),
                             8'($urandom), 8'($urandom), 8'($urandom));
            end else if (roll >= 95) begin
                send_request(REQ_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                             8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                random_load();
            end
        end
        random_read();
    endtask

    // Receiver: ready bursts of varied length with gaps, plus one long hold-off.
    initial begin
        int burst;
        int gap;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 4);
            m_tready <= 1'b1;
            repeat (burst) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // Main sequence: reset, directed requests, random phases, verdict.
    initial begin
        int phase_idx;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A write to the unused register index must change nothing.
        write_reg(CFG_UNUSED, '1);
        cfg_valid <= 1'b0;

        // Full 256 x 256 size: corners, rounding of the gray value, ignored kind.
        send_request(REQ_LOAD, 0, 0, 8'd255, 8'd255, 8'd255);
        send_request(REQ_LOAD, 255, 255, 8'd0, 8'd0, 8'd0);
        send_request(REQ_LOAD, 255, 0, 8'd255, 8'd0, 8'd1);
        send_request(REQ_LOAD, 0, 255, 8'd1, 8'd1, 8'd0);
        send_request(REQ_READ, 255, 255, 8'd0, 8'd0, 8'd0);
        send_request(REQ_READ, 0, 0, 8'd255, 8'd255, 8'd255);
        send_request(REQ_READ, 255, 0, 8'd0, 8'd0, 8'd0);
        send_request(REQ_READ, 0, 255, 8'd0, 8'd0, 8'd0);
        send_request(REQ_NONE, 255, 255, 8'd255, 8'd255, 8'd255);

        // 2 x 2 image: loads and reads outside it, loads inside it, then a run with zero passes.
        configure(SIZE_REG_W'(2), SIZE_REG_W'(2), PASS_W'(0));
        send_request(REQ_LOAD, 2, 0, 8'd200, 8'd100, 8'd50);
        send_request(REQ_LOAD, 0, 2, 8'd10, 8'd20, 8'd30);
        send_request(REQ_LOAD, 1, 0, channel_value(), channel_value(), channel_value());
        send_request(REQ_LOAD, 0, 1, channel_value(), channel_value(), channel_value());
        send_request(REQ_LOAD, 1, 1, channel_value(), channel_value(), channel_value());
        send_request(REQ_READ, 2, 1, 8'd0, 8'd0, 8'd0);
        send_request(REQ_READ, 255, 255, 8'd0, 8'd0, 8'd0);
        send_request(REQ_RUN, 0, 0, 8'd0, 8'd0, 8'd0);
        send_request(REQ_READ, 1, 1, 8'd0, 8'd0, 8'd0);

        // Highest pass count on the same image.
        configure(SIZE_REG_W'(2), SIZE_REG_W'(2), '1);
        send_request(REQ_RUN, 0, 0, 8'd0, 8'd0, 8'd0);
        send_request(REQ_READ, 0, 0, 8'd0, 8'd0, 8'd0);
        send_request(REQ_READ, 1, 0, 8'd0, 8'd0, 8'd0);
        send_request(REQ_READ, 0, 1, 8'd0, 8'd0, 8'd0);
        send_request(REQ_READ, 1, 1, 8'd0, 8'd0, 8'd0);

        phase_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            run_phase(phase_idx);
            phase_idx++;
        end

        wait_idle();
        if (mismatch_count == 0 && reads_pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
